// File: hw/rtl/mfk_pkg.sv
// Package: constants and types shared by the most-frequent k-mer block.
package mfk_pkg;
  localparam int MAX_LENGTH_DEF = 1024;
  localparam int MAX_WINDOW_DEF = 8;
  localparam logic [3:0] K_RESET = 4'd4;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [1:0] {
    PH_LOADING  = 2'd0,
    PH_RESULTS  = 2'd1,
    PH_SHORT    = 2'd2,
    PH_OVERFLOW = 2'd3
  } phase_t;
endpackage

// File: hw/rtl/mfk_cmp.sv
// Shared 64-bit window comparator used by the sort and scan sequencer.
module mfk_cmp import mfk_pkg::*; (
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        gt,
  output logic        eq
);
  assign gt = a > b;
  assign eq = a == b;
endmodule

// File: hw/rtl/most_frequent_kmers_core.sv
// Top level of the most-frequent k-mer block: stores, sequencer, result port.
// Symbols load one per cycle (busy stays low while loading). After the last
// symbol, unless the input overflowed or is shorter than k, busy rises while
// one sequencer reuses a single 64-bit comparator through window building,
// insertion sort (one memory read per step), scan and list compaction. A
// read request passes through S_RD_WAIT and S_RD_OUT and is answered on
// out_valid for one cycle; the receiver cannot stall, and busy is high over
// that time. Configuration writes are always taken.
module most_frequent_kmers_core import mfk_pkg::*; #(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [7:0]  in_symbol,
  input  logic        in_last_symbol,
  output logic        out_valid,
  output logic [63:0] out_kmer,
  output logic [10:0] out_top_count,
  output logic        out_last_of_list,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_k_length
);
  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_BLD_RD, S_BLD_ACC, S_INS_LD, S_INS_RD, S_INS_CMP, S_INS_PLACE,
    S_SCN_RD, S_SCN_CMP, S_RD_WAIT, S_RD_OUT
  } state_t;

  logic [7:0]  sym_mem [MAX_LENGTH];
  logic [63:0] win_mem [MAX_LENGTH];
  logic [7:0]  sym_q;
  logic [63:0] win_q;

  state_t      state_r;
  phase_t      phase_r;
  logic [3:0]  kcfg_r, k_r, t_r;
  logic [CW-1:0] len_r, n_r, i_r, j_r, run_r, best_r, start_r, lc_r, rp_r;
  logic        ovf_r, pass_r;
  logic [63:0] acc_r, v_r, prev_r;
  logic        out_valid_r, out_last_r;
  logic [63:0] out_kmer_r;
  logic [10:0] out_cnt_r;
  logic [1:0]  out_st_r;

  logic        sw_en, ww_en;
  logic [AW-1:0] s_wa, s_ra, w_wa, w_ra;
  logic [7:0]  s_wd;
  logic [63:0] w_wd;
  logic [63:0] ca, cb;
  logic        c_gt, c_eq;

  mfk_cmp u_cmp (.a(ca), .b(cb), .gt(c_gt), .eq(c_eq));

  logic accept;
  assign accept    = start && !busy;
  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_kmer  = out_kmer_r;
  assign out_top_count = out_cnt_r;
  assign out_last_of_list = out_last_r;
  assign out_status = out_st_r;

  always_ff @(posedge clk) begin
    if (sw_en) sym_mem[s_wa] <= s_wd;
    sym_q <= sym_mem[s_ra];
    if (ww_en) win_mem[w_wa] <= w_wd;
    win_q <= win_mem[w_ra];
  end

  logic [3:0] keff;
  always_comb begin
    keff = kcfg_r;
    if (keff == 4'd0) keff = 4'd1;
    if (keff > 4'(MAX_WINDOW)) keff = 4'(MAX_WINDOW);
  end

  // Comparator operands: insertion compares against v, scan against prev.
  always_comb begin
    ca = win_q;
    cb = (state_r == S_INS_CMP) ? v_r : prev_r;
  end

  // Memory ports, steered by state.
  always_comb begin
    sw_en = 1'b0; s_wa = len_r[AW-1:0]; s_wd = in_symbol;
    s_ra  = AW'(i_r + CW'(t_r));
    ww_en = 1'b0; w_wa = i_r[AW-1:0]; w_wd = acc_r; w_ra = i_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        sw_en = accept && !in_kind && (len_r < CW'(MAX_LENGTH) || phase_r != PH_LOADING);
        s_wa  = (phase_r != PH_LOADING) ? '0 : len_r[AW-1:0];
        w_ra  = rp_r[AW-1:0];
      end
      S_BLD_ACC: begin
        ww_en = (t_r == k_r - 4'd1);
        w_wd  = ({acc_r[55:0], sym_q}) << (6'(8 - k_r) * 8);
      end
      // on leaving the sort, fetch window 0 for the scan
      S_INS_RD:  w_ra = (i_r >= n_r) ? '0 : AW'(i_r - CW'(1));
      S_INS_CMP: begin
        ww_en = c_gt && j_r != '0;
        w_wa = j_r[AW-1:0]; w_wd = win_q;
        w_ra = AW'(j_r - CW'(2));
      end
      S_INS_PLACE: begin
        ww_en = 1'b1; w_wa = j_r[AW-1:0]; w_wd = v_r;
        w_ra = AW'(i_r + CW'(1));
      end
      S_SCN_RD: w_ra = AW'(1);
      S_SCN_CMP: begin
        ww_en = pass_r && (i_r == n_r || !c_eq) && (i_r - start_r == best_r);
        w_wa = lc_r[AW-1:0]; w_wd = prev_r;
        w_ra = (i_r == n_r) ? '0 : AW'(i_r + CW'(1));
      end
      S_RD_WAIT: w_ra = rp_r[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; phase_r <= PH_LOADING; kcfg_r <= K_RESET;
      len_r <= '0; ovf_r <= 1'b0; best_r <= '0; rp_r <= '0; lc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) kcfg_r <= cfg_k_length;
      case (state_r)
        S_IDLE: if (accept) begin
          if (!in_kind) begin
            logic [CW-1:0] nl;
            logic no;
            nl = (phase_r != PH_LOADING) ? '0 : len_r;
            no = (phase_r != PH_LOADING) ? 1'b0 : ovf_r;
            if (phase_r != PH_LOADING) begin
              rp_r <= '0; lc_r <= '0; best_r <= '0;
            end
            phase_r <= PH_LOADING;
            if (nl < CW'(MAX_LENGTH)) nl = nl + CW'(1);
            else no = 1'b1;
            len_r <= nl; ovf_r <= no;
            if (in_last_symbol) begin
              k_r <= keff; rp_r <= '0; lc_r <= '0; best_r <= '0;
              if (no) phase_r <= PH_OVERFLOW;
              else if (nl < CW'(keff)) phase_r <= PH_SHORT;
              else begin
                n_r <= nl - CW'(keff) + CW'(1);
                i_r <= '0; t_r <= '0; acc_r <= '0;
                state_r <= S_BLD_RD;
              end
            end
          end else state_r <= S_RD_WAIT;
        end
        S_BLD_RD: state_r <= S_BLD_ACC;
        S_BLD_ACC: begin
          if (t_r == k_r - 4'd1) begin
            acc_r <= '0; t_r <= '0;
            if (i_r + CW'(1) == n_r) begin
              i_r <= CW'(1); state_r <= S_INS_LD;
            end else begin
              i_r <= i_r + CW'(1); state_r <= S_BLD_RD;
            end
          end else begin
            acc_r <= {acc_r[55:0], sym_q}; t_r <= t_r + 4'd1;
            state_r <= S_BLD_RD;
          end
        end
        // fetch window 1 once the last window has been written
        S_INS_LD: state_r <= S_INS_RD;
        S_INS_RD: begin
          // win_q holds window i (read in the prior cycle) on entry
          if (i_r >= n_r) begin
            i_r <= '0; run_r <= '0; start_r <= '0; pass_r <= 1'b0;
            best_r <= CW'(1); state_r <= S_SCN_RD;
          end else begin
            v_r <= win_q; j_r <= i_r; state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (j_r != '0 && c_gt) j_r <= j_r - CW'(1);
          else state_r <= S_INS_PLACE;
        end
        S_INS_PLACE: begin i_r <= i_r + CW'(1); state_r <= S_INS_RD; end
        S_SCN_RD: begin
          prev_r <= win_q; i_r <= CW'(1); start_r <= '0; run_r <= CW'(1);
          lc_r <= '0; state_r <= S_SCN_CMP;
        end
        S_SCN_CMP: begin
          // pass 0 finds the best run, pass 1 compacts tied windows in place
          if (i_r == n_r || !c_eq) begin
            if (pass_r && i_r - start_r == best_r) lc_r <= lc_r + CW'(1);
            start_r <= i_r; prev_r <= win_q; run_r <= CW'(1);
          end else begin
            run_r <= run_r + CW'(1);
            if (!pass_r && run_r + CW'(1) > best_r) best_r <= run_r + CW'(1);
          end
          if (i_r == n_r) begin
            if (pass_r) begin phase_r <= PH_RESULTS; state_r <= S_IDLE; end
            else begin pass_r <= 1'b1; i_r <= '0; state_r <= S_SCN_RD; end
          end else i_r <= i_r + CW'(1);
        end
        S_RD_WAIT: state_r <= S_RD_OUT;
        S_RD_OUT: begin
          out_valid_r <= 1'b1; out_kmer_r <= '0; out_cnt_r <= '0;
          out_last_r <= 1'b0; out_st_r <= ST_NONE;
          if (phase_r == PH_SHORT) out_st_r <= ST_SHORT;
          else if (phase_r == PH_OVERFLOW) out_st_r <= ST_OVERFLOW;
          else if (phase_r == PH_RESULTS && rp_r < lc_r) begin
            out_kmer_r <= win_q; out_cnt_r <= 11'(best_r);
            out_last_r <= (rp_r + CW'(1) == lc_r); out_st_r <= ST_VALID;
            rp_r <= rp_r + CW'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
